// ===== hdl/particle_pool_update_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PPU_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication with the consequent checked in the next cycle.
`define PPU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== hdl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Types and constants for the particle pool block.
// ----------------------------------------------------------------------------
`default_nettype none
package ppu_pkg;
  localparam int unsigned PoolSize = 64;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CntW     = 7;
  localparam logic signed [15:0] PosOne    = 16'sd16384;
  localparam logic signed [15:0] PosNegOne = -16'sd16384;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_VERT  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RM_RD, ST_RM_CHK, ST_RM_CPY, ST_UP_RD, ST_UP_X, ST_UP_Y, ST_UP_Z,
    ST_UP_WR, ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz;
    logic [15:0] life;
  } part_t;
endpackage
`default_nettype wire

// ===== hdl/ppu_if.sv =====
// ----------------------------------------------------------------------------
// ppu_in_if / ppu_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppu_in_if;
  logic valid, ready;
  logic action;
  logic signed [15:0] start_x, start_y, start_z, speed_x, speed_y, speed_z;
  logic [15:0] life_span, step_time;
  modport source (output valid, action, start_x, start_y, start_z, speed_x, speed_y,
                  speed_z, life_span, step_time, input ready);
  modport sink (input valid, action, start_x, start_y, start_z, speed_x, speed_y,
                speed_z, life_span, step_time, output ready);
endinterface

interface ppu_out_if;
  logic valid, ready;
  logic [1:0] kind;
  logic dropped, last;
  logic [5:0] slot;
  logic signed [15:0] out_x, out_neg_y, out_z;
  modport source (output valid, kind, dropped, slot, out_x, out_neg_y, out_z, last,
                  input ready);
  modport sink (input valid, kind, dropped, slot, out_x, out_neg_y, out_z, last,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/ppu_ram.sv =====
// ----------------------------------------------------------------------------
// ppu_ram
// Particle store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_ram import ppu_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [SlotW-1:0] waddr_i,
  input  part_t                 wdata_i,
  input  wire logic [SlotW-1:0] raddr_i,
  output part_t                 rdata_o
);
  part_t mem [PoolSize];
  // Write and read the store
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/ppu_axis.sv =====
// ----------------------------------------------------------------------------
// ppu_axis
// Shared motion unit: multiply, round, add and clamp one coordinate.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_axis import ppu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [15:0] pos_i,
  input  wire logic signed [15:0] vel_i,
  input  wire logic [15:0]        dt_i,
  output logic signed [15:0]      pos_o
);
  logic signed [32:0] prod_q;
  logic signed [15:0] pos_q;
  logic signed [24:0] step;
  logic signed [25:0] sum;
  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= vel_i * $signed({1'b0, dt_i});
    pos_q  <= pos_i;
  end
  // Round to nearest, add and clamp
  always_comb begin
    step = 25'((prod_q + 33'sd128) >>> 8);
    sum  = 26'(step) + 26'(pos_q);
    if (sum > 26'(PosOne)) pos_o = PosOne;
    else if (sum < 26'(PosNegOne)) pos_o = PosNegOne;
    else pos_o = sum[15:0];
  end
endmodule
`default_nettype wire

// ===== hdl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with create, swap-remove and motion update per tick.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  in_if   | in  | action, start/speed xyz, life_span, step_time
//  out_if  | out | kind, dropped, slot, out_x/neg_y/z, last
// Create: accept, then result. Tick: a removal pass that reads and checks each
// slot and copies the last particle over an expired one, then an update of each
// live particle through the store's registered read and the shared motion unit,
// which handles x, y and z in turn. Reset clears the count and sequencer; the
// store needs no clearing. A stalled result holds the sequencer and the input.
`default_nettype none
module particle_pool_update import ppu_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  ppu_in_if.sink   in_if,
  ppu_out_if.source out_if
);
  state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [15:0] dt_q, dt_d;
  part_t cur_q, cur_d, rdat, wdat;
  logic we;
  logic [SlotW-1:0] waddr, raddr;
  logic ov_q, ov_d, olast_q, olast_d, odrop_q, odrop_d;
  logic [1:0] okind_q, okind_d;
  logic [SlotW-1:0] oslot_q, oslot_d;
  logic signed [15:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic signed [15:0] ax_pos, ax_vel, ax_out;
  logic [15:0] life_nx;
  state_e ret_q, ret_d;

  ppu_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdat), .raddr_i(raddr),
                 .rdata_o(rdat));
  ppu_axis u_axis (.clk_i, .pos_i(ax_pos), .vel_i(ax_vel), .dt_i(dt_q), .pos_o(ax_out));

  assign in_if.ready = (st_q == ST_IDLE) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.kind = okind_q;
  assign out_if.dropped = odrop_q;
  assign out_if.slot = oslot_q;
  assign out_if.out_x = ox_q;
  assign out_if.out_neg_y = oy_q;
  assign out_if.out_z = oz_q;
  assign out_if.last = olast_q;
  assign life_nx = (cur_q.life > dt_q) ? cur_q.life - dt_q : 16'd0;

  // Hold state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ret_q <= ST_IDLE; cnt_q <= '0; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; cnt_q <= cnt_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) begin
    dt_q <= dt_d; cur_q <= cur_d; okind_q <= okind_d; odrop_q <= odrop_d;
    oslot_q <= oslot_d; ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d; olast_q <= olast_d;
  end

  // Sequence create, removal and update
  always_comb begin
    st_d = st_q; ret_d = ret_q; cnt_d = cnt_q; idx_d = idx_q; dt_d = dt_q;
    cur_d = cur_q; ov_d = ov_q; okind_d = okind_q; odrop_d = odrop_q;
    oslot_d = oslot_q; ox_d = ox_q; oy_d = oy_q; oz_d = oz_q; olast_d = olast_q;
    we = 1'b0; waddr = idx_q[SlotW-1:0]; wdat = cur_q; raddr = idx_q[SlotW-1:0];
    ax_pos = cur_q.px; ax_vel = cur_q.vx;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          ox_d = '0; oy_d = '0; oz_d = '0; odrop_d = 1'b0; olast_d = 1'b1;
          oslot_d = '0; idx_d = '0; dt_d = in_if.step_time;
          if (!in_if.action) begin
            okind_d = KIND_ACK; ov_d = 1'b1;
            if (cnt_q >= CntW'(PoolSize)) odrop_d = 1'b1;
            else begin
              we = 1'b1; waddr = cnt_q[SlotW-1:0];
              wdat = '{in_if.start_x, in_if.start_y, in_if.start_z, in_if.speed_x,
                       in_if.speed_y, in_if.speed_z, in_if.life_span};
              oslot_d = cnt_q[SlotW-1:0]; cnt_d = cnt_q + 1'b1;
            end
          end else st_d = ST_RM_RD;
        end
      end
      ST_RM_RD: begin
        if (idx_q >= cnt_q) begin
          idx_d = '0;
          if (cnt_q == '0) begin
            okind_d = KIND_EMPTY; ov_d = 1'b1; st_d = ST_IDLE;
          end else st_d = ST_UP_RD;
        end else st_d = ST_RM_CHK;
      end
      ST_RM_CHK: begin
        if (rdat.life == '0) begin
          raddr = 6'(cnt_q - 1'b1); st_d = ST_RM_CPY;
        end else begin
          idx_d = idx_q + 1'b1; st_d = ST_RM_RD;
        end
      end
      ST_RM_CPY: begin
        we = 1'b1; wdat = rdat; cnt_d = cnt_q - 1'b1; st_d = ST_RM_RD;
      end
      // Hold until the previous vertex has left the result registers
      ST_UP_RD: begin
        if (!ov_q || out_if.ready) st_d = ST_UP_X;
      end
      ST_UP_X: begin
        cur_d = rdat; ax_pos = rdat.px; ax_vel = rdat.vx; st_d = ST_UP_Y;
      end
      ST_UP_Y: begin
        ox_d = ax_out; ax_pos = cur_q.py; ax_vel = cur_q.vy; st_d = ST_UP_Z;
      end
      ST_UP_Z: begin
        oy_d = ax_out; ax_pos = cur_q.pz; ax_vel = cur_q.vz; st_d = ST_UP_WR;
      end
      ST_UP_WR: begin
        oz_d = ax_out; st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q) begin
          we = 1'b1;
          wdat = '{ox_q, oy_q, oz_q, cur_q.vx, cur_q.vy, cur_q.vz, life_nx};
          oy_d = -oy_q; okind_d = KIND_VERT; odrop_d = 1'b0;
          oslot_d = idx_q[SlotW-1:0]; olast_d = (idx_q + 1'b1 == cnt_q);
          ov_d = 1'b1; idx_d = idx_q + 1'b1;
          st_d = (idx_q + 1'b1 == cnt_q) ? ST_IDLE : ST_UP_RD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ppu_checker.sv =====
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks on the particle pool block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_pool_update_defines.svh"
module ppu_checker import ppu_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready, out_valid, out_ready, out_dropped, out_last,
  input wire logic [1:0] out_kind
);
  `PPU_ASSERT_IMPL(a_drop_ack, clk_i, rst_ni, out_valid && out_dropped, out_kind == KIND_ACK, "drop not ack")
  `PPU_ASSERT_IMPL(a_ack_last, clk_i, rst_ni, out_valid && out_kind != KIND_VERT, out_last, "single result lacks last")
  `PPU_ASSERT_IMPL(a_no_ready, clk_i, rst_ni, out_valid, !in_ready, "input taken during result")
  `PPU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind particle_pool_update ppu_checker u_chk (
  .clk_i, .rst_ni, .in_ready(in_if.ready), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_dropped(out_if.dropped), .out_last(out_if.last),
  .out_kind(out_if.kind));
`default_nettype wire

// ===== sim/ppu_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_tb_pkg
// Shared testbench types for the particle pool test.
// ----------------------------------------------------------------------------
package ppu_tb_pkg;
  import ppu_pkg::*;

  typedef enum logic {
    ACT_CREATE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  // One result transaction as seen on the output channel
  typedef struct packed {
    kind_e              kind;
    logic               dropped;
    logic [5:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] ny;
    logic signed [15:0] z;
    logic               last;
  } vertex_t;
endpackage

// ===== sim/particle_pool_update_test.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update_test
// Drives create and tick transactions into the particle pool, tracks the pool
// in a local shadow copy and checks every result transaction in order.
// ----------------------------------------------------------------------------
module particle_pool_update_test;
  import ppu_pkg::*;
  import ppu_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  ppu_in_if  in_if ();
  ppu_out_if out_if ();

  particle_pool_update dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Shadow pool
  int          pool_cnt;
  part_t       pool [PoolSize];
  vertex_t     pending_q [$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          mismatch_cnt;
  int          result_cnt;
  int          create_cnt;
  int          tick_cnt;
  int          drop_cnt;
  int          empty_cnt;
  bit          timed_out;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #80ms;
    $display("particle_pool_update_test NOT OK");
    $finish;
  end

  // Rounded motion step, clamped to +-1.0
  function automatic logic signed [15:0] move_axis(logic signed [15:0] pos,
                                                   logic signed [15:0] vel,
                                                   logic [15:0] dt);
    longint prod;
    longint np;
    prod = longint'(vel) * longint'({1'b0, dt});
    np = longint'(pos) + ((prod + 128) >>> 8);
    if (np > 16384) np = 16384;
    if (np < -16384) np = -16384;
    return np[15:0];
  endfunction

  function automatic vertex_t mk_res(kind_e k, logic d, logic [5:0] s,
                                     logic signed [15:0] x, logic signed [15:0] ny,
                                     logic signed [15:0] z, logic l);
    vertex_t r;
    r.kind = k; r.dropped = d; r.slot = s; r.x = x; r.ny = ny; r.z = z; r.last = l;
    return r;
  endfunction

  // Update the shadow pool and queue the expected results
  task automatic predict_pool(action_e act, part_t p, logic [15:0] dt);
    int i;
    logic [15:0] ny;
    if (act == ACT_CREATE) begin
      if (pool_cnt >= PoolSize) begin
        pending_q.push_back(mk_res(KIND_ACK, 1'b1, 6'd0, '0, '0, '0, 1'b1));
        drop_cnt++;
      end else begin
        pool[pool_cnt] = p;
        pending_q.push_back(mk_res(KIND_ACK, 1'b0, pool_cnt[5:0], '0, '0, '0, 1'b1));
        pool_cnt++;
      end
      return;
    end
    // swap-remove expired particles, recheck the filled slot
    i = 0;
    while (i < pool_cnt) begin
      if (pool[i].life == 16'd0) begin
        pool[i] = pool[pool_cnt - 1];
        pool_cnt--;
      end else begin
        i++;
      end
    end
    if (pool_cnt == 0) begin
      pending_q.push_back(mk_res(KIND_EMPTY, 1'b0, 6'd0, '0, '0, '0, 1'b1));
      empty_cnt++;
      return;
    end
    for (i = 0; i < pool_cnt; i++) begin
      pool[i].life = (pool[i].life > dt) ? pool[i].life - dt : 16'd0;
      pool[i].px = move_axis(pool[i].px, pool[i].vx, dt);
      pool[i].py = move_axis(pool[i].py, pool[i].vy, dt);
      pool[i].pz = move_axis(pool[i].pz, pool[i].vz, dt);
      ny = -pool[i].py;
      pending_q.push_back(mk_res(KIND_VERT, 1'b0, i[5:0], pool[i].px, ny, pool[i].pz,
                                 i == pool_cnt - 1));
    end
  endtask

  // Send one transaction and predict it on acceptance
  task automatic send_item(action_e act, part_t p, logic [15:0] dt);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.start_x   <= p.px;
    in_if.start_y   <= p.py;
    in_if.start_z   <= p.pz;
    in_if.speed_x   <= p.vx;
    in_if.speed_y   <= p.vy;
    in_if.speed_z   <= p.vz;
    in_if.life_span <= p.life;
    in_if.step_time <= dt;
    do @(posedge clk_i); while (!in_if.ready);
    predict_pool(act, p, dt);
    if (act == ACT_CREATE) create_cnt++; else tick_cnt++;
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h0000;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic part_t rand_part();
    part_t p;
    p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
    p.vx = 16'($urandom); p.vy = 16'($urandom); p.vz = 16'($urandom);
    case ($urandom_range(3))
      0: p.life = 16'd0;
      1: p.life = 16'($urandom);
      default: p.life = 16'($urandom_range(1, 1500));
    endcase
    return p;
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Directed: extremes, drops, empty ticks, expiry and rounding
  task automatic test_directed();
    part_t p;
    int k;
    int n_fill;
    send_item(ACT_TICK, '0, 16'd100);
    p = '{px: 16'sd16384, py: -16'sd16384, pz: 16'sd0, vx: 16'sh7fff,
          vy: 16'sh8000, vz: 16'sd1, life: 16'hffff};
    send_item(ACT_CREATE, p, 16'd0);
    p = '{px: -16'sd16384, py: 16'sd16384, pz: 16'sd5, vx: 16'sh8000,
          vy: 16'sh7fff, vz: -16'sd1, life: 16'd0};
    send_item(ACT_CREATE, p, 16'hffff);
    p = '{px: 16'sd0, py: 16'sd0, pz: 16'sd0, vx: 16'sd1, vy: -16'sd1,
          vz: 16'sd128, life: 16'd1};
    send_item(ACT_CREATE, p, 16'd0);
    send_item(ACT_TICK, '0, 16'd128);
    send_item(ACT_TICK, '0, 16'd1);
    send_item(ACT_TICK, '0, 16'hffff);
    send_item(ACT_TICK, '0, 16'hffff);
    send_item(ACT_TICK, '0, 16'd0);
    // fill to capacity and overflow
    n_fill = PoolSize + 2 - pool_cnt;
    for (k = 0; k < n_fill; k++) send_item(ACT_CREATE, rand_part(), 16'd0);
    send_item(ACT_CREATE, rand_part(), 16'd0);
    send_item(ACT_TICK, '0, 16'd0);
    drain_results();
  endtask

  // Random: well-formed create bursts followed by ticks
  task automatic test_random(int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(0, 6);
      repeat (burst) begin
        send_item(ACT_CREATE, rand_part(), 16'($urandom));
        sent++;
      end
      send_item(ACT_TICK, rand_part(), rand_dt());
      sent++;
    end
    drain_results();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    repeat (12) send_item(ACT_CREATE, rand_part(), 16'd0);
    repeat (4) send_item(ACT_TICK, '0, rand_dt());
    drain_results();
  endtask

  // Result checker
  always @(posedge clk_i) begin
    vertex_t got;
    vertex_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = mk_res(kind_e'(out_if.kind), out_if.dropped, out_if.slot, out_if.out_x,
                   out_if.out_neg_y, out_if.out_z, out_if.last);
      result_cnt++;
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // Receiver ready, with random stalls and long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_if.ready    <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    pool_cnt        = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_off_cycles = 0;
    mismatch_cnt    = 0;
    result_cnt      = 0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_CREATE;
    in_if.start_x   = '0;
    in_if.start_y   = '0;
    in_if.start_z   = '0;
    in_if.speed_x   = '0;
    in_if.speed_y   = '0;
    in_if.speed_z   = '0;
    in_if.life_span = '0;
    in_if.step_time = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22; recv_idle_pct = 83;
    test_directed();
    test_random(95);
    send_idle_pct = 83; recv_idle_pct = 22;
    test_random(95);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(90);

    $display("covered %0d creates (%0d dropped), %0d ticks (%0d empty), %0d results",
             create_cnt, drop_cnt, tick_cnt, empty_cnt, result_cnt);
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("particle_pool_update_test OK");
    end else begin
      $display("particle_pool_update_test NOT OK");
    end
    $finish;
  end
endmodule

// ===== particle_pool_update.f =====
+incdir+hdl
hdl/ppu_pkg.sv
hdl/ppu_if.sv
hdl/ppu_ram.sv
hdl/ppu_axis.sv
hdl/particle_pool_update.sv
hdl/ppu_checker.sv
sim/ppu_tb_pkg.sv
sim/particle_pool_update_test.sv
